/* sv/smtc_pkg.sv */
// ----------------------------------------------------------------------------
// smtc_pkg - sensor matrix toggle counter package
// Shared widths, codes and structs for the toggle counter and its column cells.
// ----------------------------------------------------------------------------
`default_nettype none

package smtc_pkg;

    localparam int COLS         = 12;
    localparam int COL_W        = 4;
    localparam int ROW_IDX_W    = 3;
    localparam int ROW_CMP_W    = 5;   // wide enough to compare against ROWS up to 16
    localparam int COUNT_W      = 16;
    localparam int ROWS_DEFAULT = 8;

    typedef enum logic
    {
        FUNC_SCAN = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    // per-column result travelling down the cell chain
    typedef struct packed
    {
        logic [COUNT_W-1:0] count;
        logic               toggled;
    } slot_t;

    // control shared by every column cell
    typedef struct packed
    {
        logic apply;      // commit the held request into the cells
        logic load_op;    // request is a load, not a scan
        logic clear_all;  // quiet pass ended: zero every counter
        logic shift;      // move results one cell toward the output
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/smtc_req_if.sv */
// ----------------------------------------------------------------------------
// smtc_req_if - row request channel
// Valid/ready channel carrying one scanned or loaded sensor row.
// ----------------------------------------------------------------------------
`default_nettype none

interface smtc_req_if;
    import smtc_pkg::*;

    logic                 valid;
    logic                 ready;
    func_t                func;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COLS-1:0]      row_bits;
    logic                 end_of_scan;

    modport source (output valid, output func, output row_index, output row_bits,
                    output end_of_scan, input ready);
    modport sink   (input valid, input func, input row_index, input row_bits,
                    input end_of_scan, output ready);
endinterface

`default_nettype wire

/* sv/smtc_rsp_if.sv */
// ----------------------------------------------------------------------------
// smtc_rsp_if - per-cell result channel
// Valid/ready channel carrying one column result of a row request.
// ----------------------------------------------------------------------------
`default_nettype none

interface smtc_rsp_if;
    import smtc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic [COUNT_W-1:0] cell_count;
    logic               cell_toggled;
    logic               row_active;
    logic               counts_cleared;
    logic               last;

    modport source (output valid, output column, output cell_count, output cell_toggled,
                    output row_active, output counts_cleared, output last, input ready);
    modport sink   (input valid, input column, input cell_count, input cell_toggled,
                    input row_active, input counts_cleared, input last, output ready);
endinterface

`default_nettype wire

/* sv/sensor_matrix_toggle_counter.sv */
// ----------------------------------------------------------------------------
// sensor_matrix_toggle_counter - toggle counters for a ROWS x 12 sensor matrix
// Counts per-cell sensor flips row by row and reports twelve results per row.
// ----------------------------------------------------------------------------
// Each request carries one sensor row. A scan request compares the row with
// the stored current row, bumps a saturating 16-bit counter for every flipped
// cell and answers with twelve results, column 0 first, the twelfth marked by
// last. A load request stores the row as current and reference row and zeroes
// its counters. When a scan pass (closed by end_of_scan) saw no active row, all
// counters are zeroed and the closing request's last result says so. A request
// is taken into a holding register and committed to the twelve column cells
// once they are idle or their last result leaves; its first result then shows
// and the results leave through the cells' shift chain at one column per cycle
// while rsp.ready is high. The next request is taken while the current results
// are still draining.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_matrix_toggle_counter #(
    parameter int ROWS = smtc_pkg::ROWS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    smtc_req_if.sink  req,
    smtc_rsp_if.source rsp
);
    import smtc_pkg::*;

    // holding register for one request
    logic                 hold_valid_reg, hold_valid_next;
    func_t                hold_func_reg;
    logic [ROW_IDX_W-1:0] hold_row_reg;
    logic [COLS-1:0]      hold_bits_reg;
    logic                 hold_eos_reg;

    // result chain control
    logic                 busy_reg, busy_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 active_reg, active_next;
    logic                 cleared_reg, cleared_next;
    logic                 scan_active_reg, scan_active_next;

    logic                 req_take;
    logic                 shift;
    logic                 done;
    logic                 apply;
    logic                 is_scan;
    logic                 row_active;
    logic                 pass_active;
    logic                 clear_all;
    logic [ROWS-1:0]      row_sel;
    logic [COLS-1:0]      diff;
    cell_ctrl_t           ctrl;
    slot_t                slot_out [COLS];
    slot_t                slot_in  [COLS];

    assign req.ready = !hold_valid_reg;
    assign req_take  = req.valid && req.ready;

    assign shift = busy_reg && rsp.ready;
    assign done  = shift && (col_reg == COL_W'(COLS - 1));
    assign apply = hold_valid_reg && (!busy_reg || done);

    // row decode; rows at or above ROWS select nothing
    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            row_sel[r] = (ROW_CMP_W'(hold_row_reg) == ROW_CMP_W'(r));
        end
    end

    assign is_scan     = (hold_func_reg == FUNC_SCAN);
    assign row_active  = is_scan && (|diff);
    assign pass_active = scan_active_reg || row_active;
    assign clear_all   = is_scan && hold_eos_reg && !pass_active;

    assign ctrl.apply     = apply;
    assign ctrl.load_op   = !is_scan;
    assign ctrl.clear_all = clear_all;
    assign ctrl.shift     = shift;

    // column cells; results shift toward cell 0, which drives the port
    genvar c;
    generate
        for (c = 0; c < COLS; c++)
        begin : g_col
            if (c == COLS - 1)
            begin : g_tail
                assign slot_in[c] = '0;
            end
            else
            begin : g_link
                assign slot_in[c] = slot_out[c+1];
            end

            smtc_cell #(
                .ROWS (ROWS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .row_sel  (row_sel),
                .new_bit  (hold_bits_reg[COLS-1-c]),
                .slot_in  (slot_in[c]),
                .slot_out (slot_out[c]),
                .diff     (diff[c])
            );
        end
    endgenerate

    always_comb
    begin
        hold_valid_next  = hold_valid_reg;
        busy_next        = busy_reg;
        col_next         = col_reg;
        active_next      = active_reg;
        cleared_next     = cleared_reg;
        scan_active_next = scan_active_reg;

        if (req_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (apply)
        begin
            hold_valid_next = 1'b0;
        end

        if (apply)
        begin
            busy_next    = 1'b1;
            col_next     = '0;
            active_next  = row_active;
            cleared_next = clear_all;
            if (is_scan)
            begin
                scan_active_next = hold_eos_reg ? 1'b0 : pass_active;
            end
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (shift)
        begin
            col_next = col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            busy_reg        <= 1'b0;
            col_reg         <= '0;
            active_reg      <= 1'b0;
            cleared_reg     <= 1'b0;
            scan_active_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg  <= hold_valid_next;
            busy_reg        <= busy_next;
            col_reg         <= col_next;
            active_reg      <= active_next;
            cleared_reg     <= cleared_next;
            scan_active_reg <= scan_active_next;
        end
    end

    // request payload, captured on accept
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            hold_func_reg <= req.func;
            hold_row_reg  <= req.row_index;
            hold_bits_reg <= req.row_bits;
            hold_eos_reg  <= req.end_of_scan;
        end
    end

    assign rsp.valid          = busy_reg;
    assign rsp.column         = col_reg;
    assign rsp.cell_count     = slot_out[0].count;
    assign rsp.cell_toggled   = slot_out[0].toggled;
    assign rsp.row_active     = active_reg;
    assign rsp.last           = (col_reg == COL_W'(COLS - 1));
    assign rsp.counts_cleared = cleared_reg && rsp.last;

endmodule

`default_nettype wire

/* sv/smtc_cell.sv */
// ----------------------------------------------------------------------------
// smtc_cell - one sensor column
// Holds the column's current/reference bits and toggle counters for all rows,
// and one result slot of the output shift chain.
// ----------------------------------------------------------------------------
`default_nettype none

module smtc_cell #(
    parameter int ROWS = smtc_pkg::ROWS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire smtc_pkg::cell_ctrl_t ctrl,
    input  wire logic [ROWS-1:0]      row_sel,
    input  wire logic                 new_bit,
    input  wire smtc_pkg::slot_t      slot_in,
    output smtc_pkg::slot_t           slot_out,
    output logic                      diff
);
    import smtc_pkg::*;

    logic [ROWS-1:0]    cur_reg, cur_next;
    logic [ROWS-1:0]    ref_reg, ref_next;
    logic [COUNT_W-1:0] cnt_reg  [ROWS];
    logic [COUNT_W-1:0] cnt_next [ROWS];
    slot_t              slot_reg, slot_next;

    logic               row_hit;
    logic               scan_hit;
    logic               cur_sel;
    logic               ref_sel;
    logic               flip;
    logic [COUNT_W-1:0] cnt_sel;
    logic [COUNT_W-1:0] cnt_inc;

    assign row_hit  = |row_sel;
    assign scan_hit = row_hit && !ctrl.load_op;
    assign cur_sel  = |(cur_reg & row_sel);
    assign ref_sel  = |(ref_reg & row_sel);
    assign flip     = scan_hit && (new_bit ^ cur_sel);
    assign diff     = scan_hit && ((new_bit ^ cur_sel) || (new_bit ^ ref_sel));

    // one-hot row select: OR of the masked counters
    always_comb
    begin
        cnt_sel = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (row_sel[r])
            begin
                cnt_sel = cnt_sel | cnt_reg[r];
            end
        end
    end

    // saturating increment
    assign cnt_inc = (flip && (cnt_sel != {COUNT_W{1'b1}})) ? cnt_sel + 1'b1 : cnt_sel;

    always_comb
    begin
        cur_next  = cur_reg;
        ref_next  = ref_reg;
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (ctrl.apply)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                if (row_sel[r])
                begin
                    cur_next[r] = new_bit;
                    if (ctrl.load_op)
                    begin
                        ref_next[r] = new_bit;
                        cnt_next[r] = '0;
                    end
                    else
                    begin
                        cnt_next[r] = cnt_inc;
                    end
                end
                if (ctrl.clear_all)
                begin
                    cnt_next[r] = '0;
                end
            end
            // shown value is the count before any end-of-pass clear
            slot_next.count   = scan_hit ? cnt_inc : '0;
            slot_next.toggled = flip;
        end
        else if (ctrl.shift)
        begin
            slot_next = slot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            ref_reg <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                cnt_reg[r] <= '0;
            end
        end
        else
        begin
            cur_reg <= cur_next;
            ref_reg <= ref_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

`default_nettype wire
